// ===== sv/rle_sprite_level_mask_decoder_unit_defines.svh =====
// Assertion helpers shared by the decoder RTL. Each macro expects signals
// named clk and arst_n in the scope where it is used.
`ifndef RLE_SPRITE_LEVEL_MASK_DECODER_UNIT_DEFINES_SVH
`define RLE_SPRITE_LEVEL_MASK_DECODER_UNIT_DEFINES_SVH

// Property checked on every rising clock edge, ignored while reset is low.
`define RLSD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// If cond holds at one edge, result must hold at the next edge.
`define RLSD_ASSERT_NEXT(label, cond, result, msg) \
	`RLSD_ASSERT(label, (cond) |=> (result), msg)

`endif

// ===== sv/rlsd_pkg.sv =====
package rlsd_pkg;

	// Sprite geometry defaults.
	localparam int ICON_WIDTH_DEF  = 14;
	localparam int ICON_HEIGHT_DEF = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FILL_PERCENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_COLOR  = 2'd3;

	localparam int FILL_W   = 7;
	localparam int ORIGIN_W = 11;
	localparam int COLOR_W  = 16;
	localparam int COORD_W  = 12;
	localparam int HIDDEN_W = 7;

	localparam logic [FILL_W-1:0]  FILL_RESET        = 7'd100;
	localparam logic [COLOR_W-1:0] EMPTY_COLOR_RESET = 16'h4229;

	// Token layout.
	localparam int RUN_W    = 15;
	localparam int SKIP_BIT = 15;

	// Rounding-up divide by 100: (n * DIV100_MUL) >> DIV100_SH is exact for
	// n below 43690, which covers every height and fill level.
	localparam int PCT_ROUND   = 99;
	localparam int DIV100_MUL  = 10486;
	localparam int DIV100_SH   = 20;
	localparam int PCT_PROD_W  = 28;
	localparam int VISIBLE_W   = 8;

	localparam int JITTER_LEN = 14;
	localparam int JITTER_W   = 3;
	localparam int JCOL_W     = 4;

	// Per-column shift of the fill edge; columns past the table get none.
	function automatic logic signed [JITTER_W-1:0] col_jitter(input logic [JCOL_W-1:0] col);
		logic signed [JITTER_W-1:0] j;
		case (col)
			4'd0:    j = -3'sd1;
			4'd1:    j = 3'sd0;
			4'd2:    j = 3'sd1;
			4'd3:    j = 3'sd0;
			4'd4:    j = 3'sd2;
			4'd5:    j = 3'sd1;
			4'd6:    j = 3'sd0;
			4'd7:    j = -3'sd1;
			4'd8:    j = 3'sd1;
			4'd9:    j = 3'sd0;
			4'd10:   j = 3'sd2;
			4'd11:   j = 3'sd0;
			4'd12:   j = -3'sd1;
			4'd13:   j = 3'sd1;
			default: j = 3'sd0;
		endcase
		return j;
	endfunction

	typedef struct packed {
		logic [15:0] stream_word;
		logic        last_word;
	} word_beat_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pixel_x;
		logic signed [COORD_W-1:0] pixel_y;
		logic [COLOR_W-1:0]        pixel_color;
	} pixel_beat_t;

	// Register view the placement pipeline needs.
	typedef struct packed {
		logic signed [ORIGIN_W-1:0] origin_x;
		logic signed [ORIGIN_W-1:0] origin_y;
		logic [COLOR_W-1:0]         empty_color;
		logic [HIDDEN_W-1:0]        hidden_rows;
	} place_cfg_t;

endpackage

// ===== sv/rlsd_chan_if.sv =====
interface rlsd_chan_if #(
	parameter type beat_t = logic
) ();
	logic  valid;
	logic  ready;
	beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rlsd_place.sv =====
module rlsd_place #(
	parameter int ICON_WIDTH  = rlsd_pkg::ICON_WIDTH_DEF,
	parameter int ICON_HEIGHT = rlsd_pkg::ICON_HEIGHT_DEF,
	parameter int POS_W       = $clog2(ICON_WIDTH * ICON_HEIGHT + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [POS_W-1:0]              in_pos,
	input  logic [rlsd_pkg::COLOR_W-1:0]  in_color,
	input  rlsd_pkg::place_cfg_t          cfg,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rlsd_pkg::pixel_beat_t         out_beat
);
	localparam int ROW_W   = (ICON_HEIGHT > 1) ? $clog2(ICON_HEIGHT) : 1;
	localparam int COL_W   = (ICON_WIDTH > 1) ? $clog2(ICON_WIDTH) : 1;
	// Ceiling reciprocal of the width; the shift is large enough that the
	// quotient is exact for every position in the sprite.
	localparam int ROW_SH  = POS_W + 4;
	localparam int ROW_MUL = ((1 << ROW_SH) + ICON_WIDTH - 1) / ICON_WIDTH;
	localparam int PROD_W  = POS_W + ROW_SH + 1;
	localparam int CUT_W   = rlsd_pkg::HIDDEN_W + 2;

	logic                         v_s2;
	logic [POS_W-1:0]             pos_s2;
	logic [ROW_W-1:0]             row_s2;
	logic [rlsd_pkg::COLOR_W-1:0] color_s2;
	logic                         v_s3;
	rlsd_pkg::pixel_beat_t        beat_s3;

	logic                                 rdy_s2;
	logic                                 rdy_s3;
	logic [PROD_W-1:0]                    row_prod;
	logic [POS_W-1:0]                     row_base;
	logic [POS_W-1:0]                     col_full;
	logic [COL_W-1:0]                     col;
	logic signed [rlsd_pkg::JITTER_W-1:0] jit;
	logic signed [CUT_W-1:0]              cut_raw;
	logic [rlsd_pkg::HIDDEN_W-1:0]        cut;
	logic                                 hide;
	rlsd_pkg::pixel_beat_t                beat_d;

	assign rdy_s3   = ~v_s3 | out_ready;
	assign rdy_s2   = ~v_s2 | rdy_s3;
	assign in_ready = rdy_s2;

	assign row_prod = PROD_W'(in_pos) * PROD_W'(ROW_MUL);

	always_comb begin
		row_base = POS_W'(row_s2) * POS_W'(ICON_WIDTH);
		col_full = pos_s2 - row_base;
		col      = col_full[COL_W-1:0];
		jit      = rlsd_pkg::col_jitter(rlsd_pkg::JCOL_W'(col));
		cut_raw  = $signed({2'b00, cfg.hidden_rows}) +
			$signed({{(CUT_W - rlsd_pkg::JITTER_W){jit[rlsd_pkg::JITTER_W-1]}}, jit});
		if (cfg.hidden_rows == '0) begin
			cut = '0;
		end else if (cut_raw < 0) begin
			cut = '0;
		end else if (cut_raw > CUT_W'(ICON_HEIGHT)) begin
			cut = rlsd_pkg::HIDDEN_W'(ICON_HEIGHT);
		end else begin
			cut = cut_raw[rlsd_pkg::HIDDEN_W-1:0];
		end
		hide = rlsd_pkg::HIDDEN_W'(row_s2) < cut;
		beat_d.pixel_x = {cfg.origin_x[rlsd_pkg::ORIGIN_W-1], cfg.origin_x} +
			rlsd_pkg::COORD_W'(col);
		beat_d.pixel_y = {cfg.origin_y[rlsd_pkg::ORIGIN_W-1], cfg.origin_y} +
			rlsd_pkg::COORD_W'(row_s2);
		beat_d.pixel_color = hide ? cfg.empty_color : color_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= in_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			pos_s2   <= in_pos;
			row_s2   <= row_prod[ROW_SH +: ROW_W];
			color_s2 <= in_color;
		end
		if (rdy_s3 && v_s2) begin
			beat_s3 <= beat_d;
		end
	end

	assign out_valid = v_s3;
	assign out_beat  = beat_s3;
endmodule

// ===== sv/rle_sprite_level_mask_decoder_unit.sv =====
// Run-length sprite decoder with a fill-level mask.
//
// The words channel carries one beat per coded 16-bit word of an RGB565
// sprite; last_word marks the final beat, after which the decoder starts
// over at the top-left pixel. A token beat either skips pixels or announces
// literal colour beats; each literal beat inside the sprite yields exactly one
// pixel beat with its screen position and colour. Tokens produce none.
// The configuration port writes fill level, origin and empty colour; the user
// must write it only while no pixel is in flight; the block does not enforce it.
//
// A literal accepted from words passes through the input register, the
// row-divide stage and the output register before it is offered on the
// pixels channel. One word is accepted per cycle as long as the receiver
// keeps up; the only loop is the position/literal-count update, one add and
// compare per word.
// When the receiver stalls, the three stage registers fill up in turn and
// words stays ready until all of them hold a beat.
// Reset clears the decoder position, empties the pipeline and restores the
// registers to 100 percent fill, origin zero and the default empty colour.
`include "rle_sprite_level_mask_decoder_unit_defines.svh"

module rle_sprite_level_mask_decoder_unit #(
	parameter int ICON_WIDTH  = rlsd_pkg::ICON_WIDTH_DEF,
	parameter int ICON_HEIGHT = rlsd_pkg::ICON_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rlsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rlsd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	rlsd_chan_if.sink                         words,
	rlsd_chan_if.source                       pixels
);
	localparam int TOTAL = ICON_WIDTH * ICON_HEIGHT;
	localparam int POS_W = $clog2(TOTAL + 1);
	localparam int SUM_W = rlsd_pkg::RUN_W + 1;
	localparam int NUM_W = $clog2(ICON_HEIGHT * 127 + rlsd_pkg::PCT_ROUND + 1);
	localparam int VIS_W = rlsd_pkg::VISIBLE_W;

	// Configuration registers.
	logic [rlsd_pkg::FILL_W-1:0]          fill_q;
	logic signed [rlsd_pkg::ORIGIN_W-1:0] origin_x_q;
	logic signed [rlsd_pkg::ORIGIN_W-1:0] origin_y_q;
	logic [rlsd_pkg::COLOR_W-1:0]         empty_color_q;
	logic [rlsd_pkg::HIDDEN_W-1:0]        hidden_q;

	// Decoder state.
	logic [POS_W-1:0]           pos_q;
	logic [rlsd_pkg::RUN_W-1:0] lit_q;

	// Input stage register.
	logic                         v_s1;
	logic [POS_W-1:0]             pos_s1;
	logic [rlsd_pkg::COLOR_W-1:0] color_s1;

	rlsd_pkg::word_beat_t       word_beat;
	rlsd_pkg::pixel_beat_t      pix_beat;
	rlsd_pkg::place_cfg_t       place_cfg;
	logic                       acc;
	logic                       rdy_s1;
	logic                       place_ready;
	logic                       full;
	logic                       emit;
	logic [rlsd_pkg::RUN_W-1:0] run;
	logic [SUM_W-1:0]           skip_sum;
	logic [POS_W-1:0]           pos_d;
	logic [rlsd_pkg::RUN_W-1:0] lit_d;

	logic [NUM_W-1:0]                pct_num;
	logic [rlsd_pkg::PCT_PROD_W-1:0] pct_prod;
	logic [VIS_W-1:0]                visible;
	logic [VIS_W-1:0]                visible_cl;

	assign word_beat = words.data;
	assign acc       = words.valid & words.ready;
	assign rdy_s1    = ~v_s1 | place_ready;
	assign words.ready = rdy_s1;

	// Visible rows = ceil(height * fill / 100), saturated at the height.
	// The hidden row count is re-registered every cycle from the fill level.
	always_comb begin
		pct_num    = NUM_W'(ICON_HEIGHT) * NUM_W'(fill_q) + NUM_W'(rlsd_pkg::PCT_ROUND);
		pct_prod   = rlsd_pkg::PCT_PROD_W'(pct_num) *
			rlsd_pkg::PCT_PROD_W'(rlsd_pkg::DIV100_MUL);
		visible    = pct_prod[rlsd_pkg::DIV100_SH +: VIS_W];
		visible_cl = (visible > VIS_W'(ICON_HEIGHT)) ? VIS_W'(ICON_HEIGHT) : visible;
	end

	// Token and literal decode. A sprite that is full ignores every word,
	// and a last beat always returns the decoder to its start.
	always_comb begin
		full     = pos_q >= POS_W'(TOTAL);
		run      = word_beat.stream_word[rlsd_pkg::RUN_W-1:0];
		skip_sum = SUM_W'(pos_q) + SUM_W'(run);
		emit     = acc & ~full & (lit_q != '0);
		pos_d    = pos_q;
		lit_d    = lit_q;
		if (acc) begin
			if (!full) begin
				if (lit_q == '0) begin
					if (run != '0) begin
						if (word_beat.stream_word[rlsd_pkg::SKIP_BIT]) begin
							pos_d = (skip_sum > SUM_W'(TOTAL)) ? POS_W'(TOTAL) :
								skip_sum[POS_W-1:0];
						end else begin
							lit_d = run;
						end
					end
				end else begin
					pos_d = pos_q + 1'b1;
					lit_d = lit_q - 1'b1;
				end
			end
			if (word_beat.last_word) begin
				pos_d = '0;
				lit_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= rlsd_pkg::FILL_RESET;
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			empty_color_q <= rlsd_pkg::EMPTY_COLOR_RESET;
			hidden_q      <= '0;
			pos_q         <= '0;
			lit_q         <= '0;
			v_s1          <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rlsd_pkg::CFG_FILL_PERCENT: begin
						fill_q <= cfg_wdata[rlsd_pkg::FILL_W-1:0];
					end
					rlsd_pkg::CFG_ORIGIN_X: begin
						origin_x_q <= cfg_wdata[rlsd_pkg::ORIGIN_W-1:0];
					end
					rlsd_pkg::CFG_ORIGIN_Y: begin
						origin_y_q <= cfg_wdata[rlsd_pkg::ORIGIN_W-1:0];
					end
					rlsd_pkg::CFG_EMPTY_COLOR: begin
						empty_color_q <= cfg_wdata[rlsd_pkg::COLOR_W-1:0];
					end
					default: begin
					end
				endcase
			end
			hidden_q <= rlsd_pkg::HIDDEN_W'(VIS_W'(ICON_HEIGHT) - visible_cl);
			pos_q    <= pos_d;
			lit_q    <= lit_d;
			if (rdy_s1) begin
				v_s1 <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pos_s1   <= pos_q;
			color_s1 <= word_beat.stream_word;
		end
	end

	assign place_cfg.origin_x    = origin_x_q;
	assign place_cfg.origin_y    = origin_y_q;
	assign place_cfg.empty_color = empty_color_q;
	assign place_cfg.hidden_rows = hidden_q;

	// Row/column split, fill mask and screen offset, two stages.
	rlsd_place #(
		.ICON_WIDTH  (ICON_WIDTH),
		.ICON_HEIGHT (ICON_HEIGHT),
		.POS_W       (POS_W)
	) u_place (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (place_ready),
		.in_pos    (pos_s1),
		.in_color  (color_s1),
		.cfg       (place_cfg),
		.out_valid (pixels.valid),
		.out_ready (pixels.ready),
		.out_beat  (pix_beat)
	);

	assign pixels.data = pix_beat;

	// A last beat leaves the decoder expecting a token at the first pixel.
	`RLSD_ASSERT_NEXT(a_last_clears, acc && word_beat.last_word,
		pos_q == '0 && lit_q == '0, "decoder state not cleared after last beat")

	// Every literal beat lands in the input stage with its own position.
	`RLSD_ASSERT_NEXT(a_emit_loads, emit, v_s1 && pos_s1 == $past(pos_q),
		"literal beat not captured by the input stage")

	// A literal beat other than the last advances the position by exactly one pixel.
	`RLSD_ASSERT_NEXT(a_emit_steps, emit && !word_beat.last_word,
		pos_q == POS_W'($past(pos_q) + 1'b1), "position did not advance on a literal")

	// The position never runs past the end of the sprite.
	`RLSD_ASSERT(a_pos_bounded, pos_q <= POS_W'(TOTAL), "position beyond sprite end")
endmodule
